// ===== hw/rtl/b64u_pkg.sv =====
// Shared types, character constants and symbol mapping functions for the base64url codec.
// Used by every module of the codec; depends on nothing else.
package b64u_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned JOB_BYTES = 4;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_DASH    = 8'h2D;
	localparam logic [7:0] CHAR_UNDER   = 8'h5F;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_SLASH   = 8'h2F;
	localparam logic [7:0] CHAR_PAD     = 8'h3D;

	localparam logic [6:0] SYM_UNKNOWN = 7'd64;

	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] data;
		logic [1:0]                last_idx;
		logic                      eom;
		logic                      bad;
	} job_t;

	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = CHAR_UPPER_A + {2'b00, v};
		end else if (v < 6'd52) begin
			c = CHAR_LOWER_A + {2'b00, v - 6'd26};
		end else if (v < 6'd62) begin
			c = CHAR_DIGIT_0 + {2'b00, v - 6'd52};
		end else if (v == 6'd62) begin
			c = CHAR_DASH;
		end else begin
			c = CHAR_UNDER;
		end
		return c;
	endfunction

	function automatic logic [6:0] dec_value(input logic [7:0] c);
		logic [6:0] v;
		case (c) inside
			[8'h41:8'h5A]: v = 7'(c - CHAR_UPPER_A);
			[8'h61:8'h7A]: v = 7'(c - CHAR_LOWER_A) + 7'd26;
			[8'h30:8'h39]: v = 7'(c - CHAR_DIGIT_0) + 7'd52;
			CHAR_DASH, CHAR_PLUS: v = 7'd62;
			CHAR_UNDER, CHAR_SLASH: v = 7'd63;
			default: v = SYM_UNKNOWN;
		endcase
		return v;
	endfunction

	function automatic logic [23:0] flush_full(input logic [17:0] bits, input logic [1:0] cnt);
		logic [23:0] f;
		case (cnt)
			2'd1: f = {bits[5:0], 18'b0};
			2'd2: f = {bits[11:0], 12'b0};
			2'd3: f = {bits[17:0], 6'b0};
			default: f = 24'b0;
		endcase
		return f;
	endfunction

endpackage

// ===== hw/rtl/b64u_front.sv =====
// Front end of the base64url codec: holds the direction and group state and turns each
// accepted item into a job of up to four result bytes. Depends on b64u_pkg.
module b64u_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	input  logic            direction,
	input  logic            accept,
	input  logic [7:0]      data_in,
	input  logic            end_of_msg,
	output logic            push,
	output b64u_pkg::job_t  job
);
	import b64u_pkg::*;

	logic        dir_q;
	logic [17:0] bits_q;
	logic [1:0]  count_q;
	logic        pad_q;
	logic        err_q;

	logic [17:0] nxt_bits;
	logic [1:0]  nxt_count;
	logic        nxt_pad;
	logic        nxt_err;
	logic        emit;
	logic [23:0] full;
	logic [31:0] dec_word;
	logic [1:0]  last;
	logic        bad;
	logic [6:0]  sym;
	logic        unknown;
	logic [5:0]  v6;
	logic [17:0] grp;
	logic [15:0] enc_bits;

	always_comb begin
		nxt_bits  = bits_q;
		nxt_count = count_q;
		nxt_pad   = pad_q;
		nxt_err   = err_q;
		emit      = 1'b0;
		full      = 24'b0;
		last      = 2'd0;
		bad       = 1'b0;
		sym       = dec_value(data_in);
		unknown   = sym[6];
		v6        = unknown ? 6'd0 : sym[5:0];
		grp       = {bits_q[11:0], v6};
		enc_bits  = {bits_q[7:0], data_in};
		if (!dir_q) begin
			if (count_q >= 2'd2) begin
				full      = {bits_q[15:0], data_in};
				emit      = 1'b1;
				last      = 2'd3;
				nxt_bits  = 18'b0;
				nxt_count = 2'd0;
				nxt_err   = 1'b0;
			end else begin
				full      = (count_q == 2'd0) ? {data_in, 16'b0} : {enc_bits, 8'b0};
				emit      = end_of_msg;
				last      = count_q + 2'd1;
				nxt_bits  = {2'b00, enc_bits};
				nxt_count = count_q + 2'd1;
				if (end_of_msg) begin
					nxt_bits  = 18'b0;
					nxt_count = 2'd0;
					nxt_err   = 1'b0;
				end
			end
		end else begin
			if (pad_q) begin
				nxt_pad = pad_q;
			end else if (data_in == CHAR_PAD) begin
				if (count_q != 2'd0) begin
					emit = 1'b1;
					full = flush_full(bits_q, count_q);
					last = (count_q == 2'd3) ? 2'd1 : 2'd0;
					bad  = err_q;
				end
				nxt_bits  = 18'b0;
				nxt_count = 2'd0;
				nxt_err   = 1'b0;
				nxt_pad   = 1'b1;
			end else if (count_q == 2'd3) begin
				emit      = 1'b1;
				full      = {bits_q, v6};
				last      = 2'd2;
				bad       = err_q | unknown;
				nxt_bits  = 18'b0;
				nxt_count = 2'd0;
				nxt_err   = 1'b0;
			end else begin
				nxt_bits  = grp;
				nxt_count = count_q + 2'd1;
				nxt_err   = err_q | unknown;
				if (end_of_msg) begin
					emit = 1'b1;
					full = flush_full(grp, count_q + 2'd1);
					last = (count_q == 2'd2) ? 2'd1 : 2'd0;
					bad  = err_q | unknown;
				end
			end
			if (end_of_msg) begin
				nxt_bits  = 18'b0;
				nxt_count = 2'd0;
				nxt_err   = 1'b0;
				nxt_pad   = 1'b0;
			end
		end
	end

	assign dec_word = {full, 8'h00};

	always_comb begin
		for (int k = 0; k < JOB_BYTES; k++) begin
			job.data[k] = dir_q ? dec_word[31-8*k -: 8] : enc_char(full[23-6*k -: 6]);
		end
		job.last_idx = last;
		job.eom      = end_of_msg;
		job.bad      = bad;
	end

	assign push = accept & emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= 1'b0;
			bits_q  <= 18'b0;
			count_q <= 2'd0;
			pad_q   <= 1'b0;
			err_q   <= 1'b0;
		end else if (cfg_valid) begin
			dir_q   <= direction;
			bits_q  <= 18'b0;
			count_q <= 2'd0;
			pad_q   <= 1'b0;
			err_q   <= 1'b0;
		end else if (accept) begin
			bits_q  <= nxt_bits;
			count_q <= nxt_count;
			pad_q   <= nxt_pad;
			err_q   <= nxt_err;
		end
	end

endmodule

// ===== hw/rtl/b64u_queue.sv =====
// Short job queue between the front and back ends of the base64url codec.
// Depends on b64u_pkg for the job type.
module b64u_queue #(
	parameter int unsigned Depth = b64u_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  b64u_pkg::job_t  push_job,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output b64u_pkg::job_t  head
);
	import b64u_pkg::*;

	localparam int unsigned PtrW = $clog2(Depth);
	localparam int unsigned CntW = $clog2(Depth + 1);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full      = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/b64u_back.sv =====
// Back end of the base64url codec: walks the head job of the queue one byte per cycle,
// while out_ready allows, into the output register and marks the last byte of each job. Depends on b64u_pkg.
module b64u_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            not_empty,
	input  b64u_pkg::job_t  head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      data_out,
	output logic            run_last,
	output logic            msg_done,
	output logic            bad_symbol
);
	import b64u_pkg::*;

	logic       out_valid_q;
	logic [1:0] idx_q;
	logic [7:0] data_q;
	logic       run_last_q;
	logic       msg_done_q;
	logic       bad_q;
	logic       load;
	logic       is_last;

	assign load    = not_empty && (!out_valid_q || out_ready);
	assign is_last = (idx_q == head.last_idx);
	assign pop     = load && is_last;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q     <= head.data[idx_q];
			run_last_q <= is_last;
			msg_done_q <= is_last && head.eom;
			bad_q      <= head.bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign data_out   = data_q;
	assign run_last   = run_last_q;
	assign msg_done   = msg_done_q;
	assign bad_symbol = bad_q;

endmodule

// ===== hw/rtl/base64url_codec.sv =====
// Top level of the streaming base64url codec: front end, job queue and back end.
// Depends on b64u_pkg, b64u_front, b64u_queue and b64u_back.
//
// Usage: write the direction register on the cfg channel (0 encodes bytes into URL-safe
// characters, 1 decodes characters into bytes) while the block is idle; every write
// also drops any partial group. cfg_ready is always high.
// Items enter on in_valid/in_ready with data_in and end_of_msg; results leave on
// out_valid/out_ready, one byte per transfer, with run_last on the last result of an
// item, msg_done on the last result of a message and bad_symbol on decoded bytes whose
// group held an unknown character.
// With an empty queue and a free output register, the first result of an item passes
// through the job queue and then the output register before it reaches the outputs.
// Throughput: while the receiver takes results, the output register delivers one result
// per cycle; a full encode group of three bytes yields four results and a decode group of
// four characters three. The input side takes one item per cycle while the job queue has room.
// Reset clears the direction to encode, all group state and the queue.
// When the receiver stalls, the output holds and the queue fills; in_ready then drops.
module base64url_codec #(
	parameter int unsigned QueueDepth = b64u_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       direction,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_in,
	input  logic       end_of_msg,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_out,
	output logic       run_last,
	output logic       msg_done,
	output logic       bad_symbol
);
	import b64u_pkg::*;

	logic full;
	logic not_empty;
	logic push;
	logic pop;
	job_t push_job;
	job_t head;

	assign cfg_ready = 1'b1;
	assign in_ready  = !full;

	b64u_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.direction  (direction),
		.accept     (in_valid && !full),
		.data_in    (data_in),
		.end_of_msg (end_of_msg),
		.push       (push),
		.job        (push_job)
	);

	b64u_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	b64u_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.not_empty  (not_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.data_out   (data_out),
		.run_last   (run_last),
		.msg_done   (msg_done),
		.bad_symbol (bad_symbol)
	);

endmodule

// ===== hw/rtl/b64u_checker.sv =====
// Port-level checker for the base64url codec, attached to the top level by a bind.
// Depends only on the ports of base64url_codec.
module b64u_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] data_out,
	input logic       run_last,
	input logic       msg_done,
	input logic       bad_symbol
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(run_last))
		else $error("Stalled result changed before its transfer.");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && msg_done |-> run_last)
		else $error("Message end flagged on a result that is not the last of its item.");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("Gap inside the results of one item.");

	a_run_bad_same: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> bad_symbol == $past(bad_symbol))
		else $error("Error flag changed within the results of one item.");

endmodule

bind base64url_codec b64u_checker u_b64u_checker (.*);
